### sv/tla_pkg.sv
// Shared types, constants and helper functions for the toroidal life automaton.
// No dependencies; used by tla_seed_gen and toroidal_life_automaton_core.
package tla_pkg;

  // Field widths of the item ports
  localparam int RowIdxW  = 4;
  localparam int RowBitsW = 16;
  localparam int SeedW    = 9;
  localparam int MaxEmit  = 16;

  // Seeding generator: i = (i * 2089) % 491, and 2089 mod 491 is 125
  localparam logic [SeedW-1:0] SEED_RESET  = 9'd10;
  localparam logic [6:0]       GEN_MUL_RED = 7'd125;
  localparam logic [SeedW-1:0] GEN_MOD     = 9'd491;
  // floor(p / 491) == (p * 68339) >> 25 for every 16-bit p
  localparam logic [16:0]      GEN_RECIP   = 17'd68339;
  localparam int               GEN_RSHIFT  = 25;
  localparam logic [2:0]       GEN_THRESH  = 3'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_SEED  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME_LAST,
    ST_PRIME_FIRST,
    ST_RUN,
    ST_SEED_ISSUE,
    ST_SEED_WAIT
  } state_e;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_QUOT,
    GEN_REDUCE
  } gen_phase_e;

  // Sequencer to generator
  typedef struct packed {
    logic load;   // take the start value
    logic start;  // run one generator step
  } gen_req_t;

  // Generator to sequencer
  typedef struct packed {
    logic done;   // new value ready this cycle
    logic alive;  // cell state that value gives
  } gen_rsp_t;

  // Residue mod 7 of a 9-bit value: octal digits sum, since 8 == 1 mod 7
  function automatic logic [2:0] mod7(input logic [SeedW-1:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

### sv/tla_seed_gen.sv
// Seeding generator: one step of i = (i * 2089) % 491 per start, through multiply, quotient and reduce.
// Depends on tla_pkg (request/response structs, constants, mod7).
module tla_seed_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tla_pkg::gen_req_t         req_i,
  input  logic [tla_pkg::SeedW-1:0] seed_start_i,
  output tla_pkg::gen_rsp_t         rsp_o
);

  tla_pkg::gen_phase_e phase_q, phase_d;

  logic [tla_pkg::SeedW-1:0] val_q, val_d;
  logic [15:0]               prod_q, prod_d;
  logic [7:0]                quot_q, quot_d;
  logic                      done_q, done_d;
  logic [32:0]               recip_prod;
  logic [15:0]               remainder;

  // Reciprocal multiply for the quotient, then subtract back
  assign recip_prod = 33'(prod_q) * 33'(tla_pkg::GEN_RECIP);
  assign remainder  = prod_q - 16'(quot_q) * 16'(tla_pkg::GEN_MOD);

  // Phase sequencing and datapath next values
  always_comb begin
    phase_d = phase_q;
    val_d   = val_q;
    prod_d  = prod_q;
    quot_d  = quot_q;
    done_d  = 1'b0;
    case (phase_q)
      tla_pkg::GEN_IDLE: begin
        if (req_i.load) begin
          val_d = seed_start_i;
        end else if (req_i.start) begin
          prod_d  = 16'(val_q) * 16'(tla_pkg::GEN_MUL_RED);
          phase_d = tla_pkg::GEN_QUOT;
        end
      end
      tla_pkg::GEN_QUOT: begin
        quot_d  = recip_prod[tla_pkg::GEN_RSHIFT +: 8];
        phase_d = tla_pkg::GEN_REDUCE;
      end
      tla_pkg::GEN_REDUCE: begin
        val_d   = remainder[tla_pkg::SeedW-1:0];
        done_d  = 1'b1;
        phase_d = tla_pkg::GEN_IDLE;
      end
      default: begin
        phase_d = tla_pkg::GEN_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tla_pkg::GEN_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prod_q <= prod_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.alive = (tla_pkg::mod7(val_q) > tla_pkg::GEN_THRESH);

endmodule

### sv/tla_row_rule.sv
// Next-generation rule for one row, from the old rows above, at and below it.
// Standalone; columns wrap at the grid edge.
module tla_row_rule #(
  parameter int GRID_SIZE = 16
) (
  input  logic [GRID_SIZE-1:0] prev_i,
  input  logic [GRID_SIZE-1:0] cur_i,
  input  logic [GRID_SIZE-1:0] next_i,
  output logic [GRID_SIZE-1:0] row_o
);

  for (genvar x = 0; x < GRID_SIZE; x++) begin : g_col
    localparam int XL = (x == 0) ? GRID_SIZE - 1 : x - 1;
    localparam int XR = (x == GRID_SIZE - 1) ? 0 : x + 1;

    logic [3:0] total;

    // Cell plus its eight neighbors
    assign total = 4'(prev_i[XL]) + 4'(prev_i[x]) + 4'(prev_i[XR])
                 + 4'(cur_i[XL])  + 4'(cur_i[x])  + 4'(cur_i[XR])
                 + 4'(next_i[XL]) + 4'(next_i[x]) + 4'(next_i[XR]);

    // Born or kept at 3 or 4, unchanged at 2, dead otherwise
    assign row_o[x] = (total == 4'd3 || total == 4'd4) ? 1'b1 :
                      (total == 4'd2) ? cur_i[x] : 1'b0;
  end

endmodule

### sv/toroidal_life_automaton_core.sv
// Top level of the toroidal life automaton: row memory, command sequencer, output word.
// Depends on tla_pkg, tla_seed_gen and tla_row_rule.
//
//  channel | signals                                   | dir | words
//  --------+-------------------------------------------+-----+---------------------------
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i        | in  | seed start value
//  in      | in_valid_i in_ready_o cmd_i row_index_i   | in  | write / step / seed command
//          | row_bits_i                                |     |
//  out     | out_valid_o out_ready_i out_row_index_o   | out | one new row per word
//          | out_row_bits_o last_row_o                 |     |
//
// Write: taken in the idle state. Step: primes the old bottom and top rows, then one row
// per cycle through the single read port of the row memory, while out_ready_i does not
// hold the output word. Seed: a read-modify-write of one cell per generator step.
// Reset clears every row through per-row valid bits; no clearing pass is needed.
// The input waits in ready low while a command runs; cfg is always ready.
module toroidal_life_automaton_core #(
  parameter int GRID_SIZE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tla_pkg::SeedW-1:0]    cfg_data_i,
  // commands
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [tla_pkg::RowIdxW-1:0]  row_index_i,
  input  logic [tla_pkg::RowBitsW-1:0] row_bits_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tla_pkg::RowIdxW-1:0]  out_row_index_o,
  output logic [tla_pkg::RowBitsW-1:0] out_row_bits_o,
  output logic                         last_row_o
);

  localparam int AW      = $clog2(GRID_SIZE);
  localparam int NumEmit = (GRID_SIZE < tla_pkg::MaxEmit) ? GRID_SIZE : tla_pkg::MaxEmit;

  tla_pkg::state_e state_q, state_d;

  logic [tla_pkg::SeedW-1:0] seed_start_q;
  logic [AW-1:0]             x_q, x_d, y_q, y_d;
  logic [AW:0]               y_plus2;
  logic [GRID_SIZE-1:0]      prev_q, prev_d, cur_q, cur_d, first_q, first_d;
  logic [GRID_SIZE-1:0]      next_row, new_row, seed_row;

  logic                         out_valid_q, out_valid_d;
  logic [tla_pkg::RowIdxW-1:0]  out_idx_q, out_idx_d;
  logic [tla_pkg::RowBitsW-1:0] out_bits_q, out_bits_d;
  logic                         out_last_q, out_last_d;
  logic                         out_load, emit, advance;

  // Row memory with per-row valid bits
  logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid_q;
  logic [GRID_SIZE-1:0] rd_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [GRID_SIZE-1:0] mem_wdata;

  tla_pkg::gen_req_t gen_req;
  tla_pkg::gen_rsp_t gen_rsp;

  tla_seed_gen u_seed_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (gen_req),
    .seed_start_i (seed_start_q),
    .rsp_o        (gen_rsp)
  );

  tla_row_rule #(
    .GRID_SIZE (GRID_SIZE)
  ) u_row_rule (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .next_i (next_row),
    .row_o  (new_row)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == tla_pkg::ST_IDLE);

  // Row below the current one; the bottom row wraps to the saved old top row
  assign next_row = (int'(y_q) == GRID_SIZE - 1) ? first_q : rd_q;
  assign y_plus2  = {1'b0, y_q} + (AW+1)'(2);

  // Seed cell update: column zero starts a cleared row
  always_comb begin
    seed_row      = (x_q == '0) ? '0 : rd_q;
    seed_row[x_q] = gen_rsp.alive;
  end

  // Output word room and whether this row is shown at all
  assign emit    = (int'(y_q) < NumEmit);
  assign advance = !emit || !out_valid_q || out_ready_i;

  // Sequencer: next state, memory strobes, window and output loads
  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    first_d    = first_q;
    mem_we     = 1'b0;
    mem_waddr  = y_q;
    mem_wdata  = new_row;
    mem_re     = 1'b0;
    mem_raddr  = y_plus2[AW-1:0];
    gen_req    = '0;
    out_load   = 1'b0;
    out_idx_d  = out_idx_q;
    out_bits_d = out_bits_q;
    out_last_d = out_last_q;
    case (state_q)
      tla_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (tla_pkg::cmd_e'(cmd_i))
            tla_pkg::CMD_WRITE: begin
              mem_we    = (int'(row_index_i) < GRID_SIZE);
              mem_waddr = AW'(row_index_i);
              mem_wdata = GRID_SIZE'(row_bits_i);
            end
            tla_pkg::CMD_STEP: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(GRID_SIZE - 1);
              state_d   = tla_pkg::ST_PRIME_LAST;
            end
            tla_pkg::CMD_SEED: begin
              gen_req.load = 1'b1;
              x_d          = '0;
              y_d          = '0;
              state_d      = tla_pkg::ST_SEED_ISSUE;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      tla_pkg::ST_PRIME_LAST: begin
        prev_d    = rd_q;
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = tla_pkg::ST_PRIME_FIRST;
      end
      tla_pkg::ST_PRIME_FIRST: begin
        cur_d     = rd_q;
        first_d   = rd_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        y_d       = '0;
        state_d   = tla_pkg::ST_RUN;
      end
      tla_pkg::ST_RUN: begin
        if (advance) begin
          mem_we = 1'b1;
          mem_re = (int'(y_plus2) < GRID_SIZE);
          prev_d = cur_q;
          cur_d  = next_row;
          if (emit) begin
            out_load   = 1'b1;
            out_idx_d  = tla_pkg::RowIdxW'(y_q);
            out_bits_d = tla_pkg::RowBitsW'(new_row);
            out_last_d = (int'(y_q) == NumEmit - 1);
          end
          if (int'(y_q) == GRID_SIZE - 1) begin
            state_d = tla_pkg::ST_IDLE;
          end else begin
            y_d = y_q + AW'(1);
          end
        end
      end
      tla_pkg::ST_SEED_ISSUE: begin
        mem_re        = 1'b1;
        mem_raddr     = y_q;
        gen_req.start = 1'b1;
        state_d       = tla_pkg::ST_SEED_WAIT;
      end
      tla_pkg::ST_SEED_WAIT: begin
        if (gen_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = y_q;
          mem_wdata = seed_row;
          state_d   = tla_pkg::ST_SEED_ISSUE;
          if (int'(y_q) == GRID_SIZE - 1) begin
            y_d = '0;
            if (int'(x_q) == GRID_SIZE - 1) begin
              state_d = tla_pkg::ST_IDLE;
            end else begin
              x_d = x_q + AW'(1);
            end
          end else begin
            y_d = y_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = tla_pkg::ST_IDLE;
      end
    endcase
  end

  // Output word valid: cleared when taken, set when a row is loaded
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tla_pkg::ST_IDLE;
      seed_start_q <= tla_pkg::SEED_RESET;
      out_valid_q  <= 1'b0;
      row_valid_q  <= '0;
      x_q          <= '0;
      y_q          <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      y_q         <= y_d;
      if (cfg_valid_i) begin
        seed_start_q <= cfg_data_i;
      end
      if (mem_we) begin
        row_valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Row window and output word payload
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    first_q    <= first_d;
    out_idx_q  <= out_idx_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= row_valid_q[mem_raddr] ? mem_q[mem_raddr] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_index_o = out_idx_q;
  assign out_row_bits_o  = out_bits_q;
  assign last_row_o      = out_last_q;

`ifndef ASSERT_OFF
  // A row is never read in the cycle it is rewritten
  a_no_rw_same_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("row memory read and write hit the same row");

  // A new row never overwrites a word still waiting
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before taken");

  // Generator results arrive only while the seed sequencer waits for them
  a_gen_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_rsp.done |-> (state_q == tla_pkg::ST_SEED_WAIT))
    else $error("generator result outside a seed pass");

  // The marked word carries the final shown row
  a_last_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |-> (out_row_index_o == tla_pkg::RowIdxW'(NumEmit - 1)))
    else $error("last row marker on the wrong row");

  // A step leaves the run state only with its bottom row
  a_run_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tla_pkg::ST_RUN && state_d == tla_pkg::ST_IDLE)
      |-> (int'(y_q) == GRID_SIZE - 1))
    else $error("step left before the bottom row");
`endif

endmodule
